[rtl/kpl_pkg.sv]
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared constants, types and the key hit test for the touch keypad PIN lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

  localparam int MAX_DIGITS  = 7;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int PIN_DIGITS  = 7;
  localparam int PIN_W       = 4 * PIN_DIGITS;
  localparam int PIN_LEN_W   = 3;
  localparam int CMP_DIGITS  = (MAX_DIGITS < PIN_DIGITS) ? MAX_DIGITS : PIN_DIGITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TX_W = 10;
  localparam int TY_W = 9;

  localparam int SCREEN_W   = 800;
  localparam int KEY_W      = 90;
  localparam int KEY_H      = 65;
  localparam int KEY_GAP    = 20;
  localparam int PAD_X0     = (SCREEN_W / 2) - (3 * KEY_W + 2 * KEY_GAP) / 2;
  localparam int PAD_Y0     = 100;
  localparam int COL2_SHIFT = 15;

  localparam int COL_LEFT [3] = '{
    PAD_X0,
    PAD_X0 + (KEY_W + KEY_GAP),
    PAD_X0 + 2 * (KEY_W + KEY_GAP) - COL2_SHIFT
  };
  localparam int ROW_TOP [4] = '{
    PAD_Y0,
    PAD_Y0 + (KEY_H + KEY_GAP) + 10,
    PAD_Y0 + 2 * (KEY_H + KEY_GAP) + 25,
    PAD_Y0 + 3 * (KEY_H + KEY_GAP) + 40
  };

  localparam logic [3:0] KEY_CLR  = 4'd10;
  localparam logic [3:0] KEY_OK   = 4'd11;
  localparam logic [3:0] KEY_NONE = 4'd12;

  localparam logic [3:0] KEY_MAP [4][3] = '{
    '{4'd1, 4'd2, 4'd3},
    '{4'd4, 4'd5, 4'd6},
    '{4'd7, 4'd8, 4'd9},
    '{KEY_CLR, 4'd0, KEY_OK}
  };

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_STORED  = 3'd1;
  localparam logic [2:0] EV_DROPPED = 3'd2;
  localparam logic [2:0] EV_CLEARED = 3'd3;
  localparam logic [2:0] EV_GRANTED = 3'd4;
  localparam logic [2:0] EV_DENIED  = 3'd5;
  localparam logic [2:0] EV_MISS    = 3'd6;

  localparam logic REG_PIN_DIGITS = 1'b0;
  localparam logic REG_PIN_LENGTH = 1'b1;

  typedef struct packed {
    logic       press;
    logic [3:0] key;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0]     digits;
    logic [PIN_LEN_W-1:0] length;
  } cfg_t;

  function automatic logic [3:0] hit_key(input logic [TX_W-1:0] tx,
                                         input logic [TY_W-1:0] ty);
    logic [2:0] x_hit;
    logic [3:0] y_hit;
    logic [3:0] key;
    key = KEY_NONE;
    for (int c = 0; c < 3; c++) begin
      x_hit[c] = (tx >= TX_W'(COL_LEFT[c])) && (tx <= TX_W'(COL_LEFT[c] + KEY_W));
    end
    for (int r = 0; r < 4; r++) begin
      y_hit[r] = (ty >= TY_W'(ROW_TOP[r])) && (ty <= TY_W'(ROW_TOP[r] + KEY_H));
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (y_hit[r] && x_hit[c]) begin
          key = KEY_MAP[r][c];
        end
      end
    end
    return key;
  endfunction

endpackage

[rtl/touch_keypad_pin_lock_top.sv]
// ----------------------------------------------------------------------------
// touch_keypad_pin_lock_top
// Touch keypad PIN lock: debounces touch samples, decodes key presses and
// checks entered digits against the configured PIN.
//
// Input channel (in_valid/in_ready): one touch sample per word, touched flag
// plus X and Y pixel coordinates. Output channel (out_valid/out_ready): exactly
// one result word per sample, carrying the event, the key and the number of
// digits held. Samples and results keep their order.
// Path: an accepted sample is written into the queue, then popped into the
// registered result stage. Throughput: one sample per cycle while the receiver
// does not stall, set by the debounce/hit test in front and the entry update in
// back, both combinational logic ahead of a register. A two-word queue between
// them and the output register let the input keep accepting while a result
// waits; when the receiver stalls, the queue fills and in_ready drops.
// Reset (rst_n low, synchronous) returns debounce to idle, empties the entry
// buffer and the queue, and clears the PIN registers to zero. The APB port
// holds the PIN digits at address 0 and the PIN length at address 4.
// ----------------------------------------------------------------------------
module touch_keypad_pin_lock_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_touched,
  input  logic [kpl_pkg::TX_W-1:0] in_touch_x,
  input  logic [kpl_pkg::TY_W-1:0] in_touch_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_event_res,
  output logic [3:0]               out_key_code,
  output logic [2:0]               out_entered_count,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import kpl_pkg::*;

  cfg_t  cfg_r;
  logic  cfg_wr;
  logic  q_full;
  logic  q_push;
  item_t push_item;
  logic  q_pop;
  logic  q_valid;
  item_t head_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PIN_DIGITS: cfg_r.digits <= pwdata[PIN_W-1:0];
        REG_PIN_LENGTH: cfg_r.length <= pwdata[PIN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PIN_DIGITS: prdata = 32'(cfg_r.digits);
      REG_PIN_LENGTH: prdata = 32'(cfg_r.length);
      default:        prdata = '0;
    endcase
  end

  kpl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_touched (in_touched),
    .in_touch_x (in_touch_x),
    .in_touch_y (in_touch_y),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  kpl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  kpl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (head_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_key_code      (out_key_code),
    .out_entered_count (out_entered_count)
  );

endmodule

[rtl/kpl_front.sv]
// ----------------------------------------------------------------------------
// kpl_front
// Debounce of touch samples and hit test of confirmed presses.
// ----------------------------------------------------------------------------
module kpl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_touched,
  input  logic [kpl_pkg::TX_W-1:0] in_touch_x,
  input  logic [kpl_pkg::TY_W-1:0] in_touch_y,
  input  logic                  q_full,
  output logic                  q_push,
  output kpl_pkg::item_t        q_item
);
  import kpl_pkg::*;

  localparam logic [1:0] PH_IDLE          = 2'd0;
  localparam logic [1:0] PH_PRESS_CHECK   = 2'd1;
  localparam logic [1:0] PH_HELD          = 2'd2;
  localparam logic [1:0] PH_RELEASE_CHECK = 2'd3;

  logic [1:0] phase_r;
  logic [1:0] phase_nxt;
  logic       press;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign press    = (phase_r == PH_PRESS_CHECK) && in_touched;

  always_comb begin
    q_item.press = press;
    q_item.key   = press ? hit_key(in_touch_x, in_touch_y) : KEY_NONE;
  end

  always_comb begin
    unique case (phase_r)
      PH_IDLE:          phase_nxt = in_touched ? PH_PRESS_CHECK : PH_IDLE;
      PH_PRESS_CHECK:   phase_nxt = in_touched ? PH_HELD : PH_IDLE;
      PH_HELD:          phase_nxt = in_touched ? PH_HELD : PH_RELEASE_CHECK;
      PH_RELEASE_CHECK: phase_nxt = in_touched ? PH_HELD : PH_IDLE;
      default:          phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (q_push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

[rtl/kpl_queue.sv]
// ----------------------------------------------------------------------------
// kpl_queue
// Short queue of classified samples between debounce and entry logic.
// ----------------------------------------------------------------------------
module kpl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kpl_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output kpl_pkg::item_t head_item
);
  import kpl_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");
`endif

endmodule

[rtl/kpl_back.sv]
// ----------------------------------------------------------------------------
// kpl_back
// Entry buffer, PIN compare and registered result stage.
// ----------------------------------------------------------------------------
module kpl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  kpl_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  kpl_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_event_res,
  output logic [3:0]     out_key_code,
  output logic [2:0]     out_entered_count
);
  import kpl_pkg::*;

  logic [3:0]       digits_r [MAX_DIGITS];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [2:0]       event_r;
  logic [2:0]       event_nxt;
  logic [3:0]       key_r;
  logic             match;
  logic             store;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    match = (int'(count_r) == int'(cfg.length));
    for (int i = 0; i < CMP_DIGITS; i++) begin
      if ((int'(count_r) > i) && (digits_r[i] != cfg.digits[4*i +: 4])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    event_nxt = EV_NONE;
    count_nxt = count_r;
    store     = 1'b0;
    if (q_item.press) begin
      priority if (q_item.key == KEY_NONE) begin
        event_nxt = EV_MISS;
      end else if (q_item.key == KEY_CLR) begin
        event_nxt = EV_CLEARED;
        count_nxt = '0;
      end else if (q_item.key == KEY_OK) begin
        event_nxt = match ? EV_GRANTED : EV_DENIED;
        count_nxt = '0;
      end else if (int'(count_r) < MAX_DIGITS) begin
        event_nxt = EV_STORED;
        count_nxt = count_r + 1'b1;
        store     = 1'b1;
      end else begin
        event_nxt = EV_DROPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (q_pop && store && (int'(count_r) == i)) begin
        digits_r[i] <= q_item.key;
      end
    end
    if (q_pop) begin
      event_r <= event_nxt;
      key_r   <= q_item.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = event_r;
  assign out_key_code      = key_r;
  assign out_entered_count = 3'(count_r);

`ifndef NO_ASSERTIONS
  a_verdict_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (event_r == EV_GRANTED || event_r == EV_DENIED))
      |-> (key_r == KEY_OK && count_r == '0)) else $error("verdict without OK");
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && event_r == EV_CLEARED) |-> count_r == '0)
    else $error("clear left digits");
  a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && store) |=> (count_r == $past(count_r) + 1'b1 && event_r == EV_STORED))
    else $error("store count slip");
`endif

endmodule
